// File: sv/mansm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mansm_pkg
// Shared types and constants of the max absolute neighbour slope map.
// ----------------------------------------------------------------------------
package mansm_pkg;

  localparam int unsigned MAX_ROW_LENGTH_DEF = 2048;

  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned SLOPE_W      = 15;
  localparam int unsigned ROW_LENGTH_W = 12;
  localparam int unsigned ROW_COUNT_W  = 16;
  localparam int unsigned ROW_W        = 17;
  localparam int unsigned CFG_IDX_W    = 8;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned NEIGH_N      = 8;

  localparam logic [ROW_LENGTH_W-1:0] ROW_LENGTH_RST = 12'd2048;
  localparam logic [ROW_COUNT_W-1:0]  ROW_COUNT_RST  = 16'd2048;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 8'd1;

  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [SLOPE_W-1:0] SLOPE_MAX = 15'h7FFF;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic    cmd;
    sample_t height;
  } in_item_t;

  typedef struct packed {
    logic [SLOPE_W-1:0] slope;
    logic               last_of_frame;
  } out_item_t;

  typedef struct packed {
    sample_t upper;
    sample_t lower;
  } line_pair_t;

endpackage
`default_nettype wire

// File: sv/mansm_line_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mansm_line_store
// Both line stores in one memory word, registered read with write bypass.
// ----------------------------------------------------------------------------
module mansm_line_store
  import mansm_pkg::*;
#(
  parameter int unsigned Depth = MAX_ROW_LENGTH_DEF
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        we_i,
  input  wire  [$clog2(Depth)-1:0]   waddr_i,
  input  line_pair_t                 wdata_i,
  input  wire  [$clog2(Depth)-1:0]   raddr_i,
  output line_pair_t                 rdata_o
);

  line_pair_t mem [Depth];
  line_pair_t rd_q;
  line_pair_t byp_data_q;
  logic       byp_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q       <= mem[raddr_i];
    byp_data_q <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = byp_q ? byp_data_q : rd_q;

endmodule
`default_nettype wire

// File: sv/mansm_window_max.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mansm_window_max
// Saturated absolute differences to the masked neighbors and their maximum.
// ----------------------------------------------------------------------------
module mansm_window_max
  import mansm_pkg::*;
(
  input  sample_t                  centre_i,
  input  sample_t                  neigh_i [NEIGH_N],
  input  wire     [NEIGH_N-1:0]    mask_i,
  output logic    [SLOPE_W-1:0]    slope_o
);

  logic signed [SAMPLE_W:0] diff [NEIGH_N];
  logic [SAMPLE_W-1:0]      mag  [NEIGH_N];
  logic [SLOPE_W-1:0]       sat  [NEIGH_N];
  logic [SLOPE_W-1:0]       lvl1 [NEIGH_N/2];
  logic [SLOPE_W-1:0]       lvl2 [NEIGH_N/4];

  always_comb begin
    for (int i = 0; i < NEIGH_N; i++) begin
      diff[i] = {centre_i[SAMPLE_W-1], centre_i} - {neigh_i[i][SAMPLE_W-1], neigh_i[i]};
      mag[i]  = diff[i][SAMPLE_W] ? SAMPLE_W'(-diff[i]) : diff[i][SAMPLE_W-1:0];
      if (!mask_i[i]) begin
        sat[i] = '0;
      end else if (mag[i][SAMPLE_W-1]) begin
        sat[i] = SLOPE_MAX;
      end else begin
        sat[i] = mag[i][SLOPE_W-1:0];
      end
    end
    for (int j = 0; j < NEIGH_N/2; j++) begin
      lvl1[j] = (sat[2*j] > sat[2*j+1]) ? sat[2*j] : sat[2*j+1];
    end
    for (int k = 0; k < NEIGH_N/4; k++) begin
      lvl2[k] = (lvl1[2*k] > lvl1[2*k+1]) ? lvl1[2*k] : lvl1[2*k+1];
    end
    slope_o = (lvl2[0] > lvl2[1]) ? lvl2[0] : lvl2[1];
  end

endmodule
`default_nettype wire

// File: sv/max_abs_neighbour_slope_map_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// max_abs_neighbour_slope_map_top
// Streams signed 16-bit height samples in raster order and returns, for each
// position, the largest saturated absolute difference to its in-frame 3x3
// neighbors (0 when there are none). One transaction is taken per clock
// while the output does not back up; the rate is set by the single registered
// read port of the line store, which serves the next column every cycle. The
// result of a position follows row_length + 1 transactions after its own
// sample and then leaves through the window stage and the output register, so a
// frame needs row_length + 1 drain transactions (cmd = 1) after its last
// sample; last_of_frame marks the frame's final result. A drain before the
// frame's last sample is ignored, a sample after it counts as a drain.
// ----------------------------------------------------------------------------
module max_abs_neighbour_slope_map_top
  import mansm_pkg::*;
#(
  parameter int unsigned MAX_ROW_LENGTH = MAX_ROW_LENGTH_DEF
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  in_item_t                in_data_i,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output out_item_t               out_data_o,
  input  wire                     cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire  [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned COL_W = $clog2(MAX_ROW_LENGTH);
  localparam int unsigned LEN_W = COL_W + 1;
  localparam int unsigned CMP_W = (LEN_W > ROW_LENGTH_W) ? LEN_W : ROW_LENGTH_W;

  typedef struct packed {
    logic [NEIGH_N-1:0] mask;
    logic               last;
  } s1_ctl_t;

  // configuration
  logic [ROW_LENGTH_W-1:0] row_length_q;
  logic [ROW_COUNT_W-1:0]  row_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= ROW_LENGTH_RST;
      row_count_q  <= ROW_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ROW_LENGTH: row_length_q <= cfg_data_i[ROW_LENGTH_W-1:0];
        CFG_ROW_COUNT:  row_count_q  <= cfg_data_i[ROW_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // position and control
  logic [COL_W-1:0] in_col_q, in_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d;
  logic             s1_valid_q, s1_valid_d;
  s1_ctl_t          s1_ctl_q, s1_ctl_d;
  logic             out_valid_q;
  out_item_t        out_q;
  logic             s2_take;

  logic [ROW_COUNT_W-1:0] rows;
  logic [ROW_W-1:0]       rows_ext;
  logic [CMP_W-1:0]       rl_ext;
  logic [LEN_W-1:0]       len;
  logic [LEN_W-1:0]       ic_ext;
  logic                   drain_pos, accept, act;
  sample_t                h;
  logic                   wrap_emit, mid_emit, emit;
  logic [ROW_W-1:0]       orow;
  logic [LEN_W-1:0]       ocol;
  logic                   left, right, top, bottom;
  logic                   res_valid, frame_end;

  line_pair_t             lp_rd, lp_wr;

  assign s2_take    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s2_take;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    rows      = (row_count_q == '0) ? ROW_COUNT_W'(1) : row_count_q;
    rows_ext  = ROW_W'(rows);
    rl_ext    = CMP_W'(row_length_q);
    if (row_length_q == '0) begin
      len = LEN_W'(1);
    end else if (rl_ext > CMP_W'(MAX_ROW_LENGTH)) begin
      len = LEN_W'(MAX_ROW_LENGTH);
    end else begin
      len = LEN_W'(rl_ext);
    end
    drain_pos = in_row_q >= rows_ext;
    act       = accept && !((in_data_i.cmd == CMD_DRAIN) && !drain_pos);
    h         = drain_pos ? sample_t'(0) : in_data_i.height;
    ic_ext    = LEN_W'(in_col_q);

    // column zero closes the last column of the row two back
    wrap_emit = (in_col_q == '0) && (in_row_q >= ROW_W'(2));
    mid_emit  = (in_col_q != '0) && (in_row_q >= ROW_W'(1));
    emit      = wrap_emit || mid_emit;
    orow      = wrap_emit ? in_row_q - ROW_W'(2) : in_row_q - ROW_W'(1);
    ocol      = wrap_emit ? len - LEN_W'(1) : ic_ext - LEN_W'(1);
    left      = wrap_emit ? (len >= LEN_W'(2)) : (ic_ext >= LEN_W'(2));
    right     = wrap_emit ? 1'b0 : (ic_ext < len);
    top       = orow != '0;
    bottom    = (orow + ROW_W'(1)) < rows_ext;
    res_valid = emit && (orow < rows_ext);
    frame_end = res_valid && (orow == rows_ext - ROW_W'(1)) && (ocol == len - LEN_W'(1));

    in_col_d = in_col_q;
    in_row_d = in_row_q;
    if (act) begin
      if (frame_end) begin
        in_col_d = '0;
        in_row_d = '0;
      end else if ((ic_ext + LEN_W'(1)) >= len) begin
        in_col_d = '0;
        in_row_d = in_row_q + ROW_W'(1);
      end else begin
        in_col_d = COL_W'(ic_ext + LEN_W'(1));
      end
    end

    s1_ctl_d.mask = {bottom & right, bottom, bottom & left, right, left,
                     top & right, top, top & left};
    s1_ctl_d.last = frame_end;

    if (act) begin
      s1_valid_d = res_valid;
    end else if (s2_take) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (act) begin
      s1_ctl_q <= s1_ctl_d;
    end
  end

  // line stores
  assign lp_wr.upper = lp_rd.lower;
  assign lp_wr.lower = h;

  mansm_line_store #(
    .Depth (MAX_ROW_LENGTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (act),
    .waddr_i (in_col_q),
    .wdata_i (lp_wr),
    .raddr_i (in_col_d),
    .rdata_o (lp_rd)
  );

  // 3x3 window, [row][col], col 2 newest
  sample_t win_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (act) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= lp_rd.upper;
      win_q[1][2] <= lp_rd.lower;
      win_q[2][2] <= h;
    end
  end

  sample_t            neigh [NEIGH_N];
  logic [SLOPE_W-1:0] slope;

  assign neigh[0] = win_q[0][0];
  assign neigh[1] = win_q[0][1];
  assign neigh[2] = win_q[0][2];
  assign neigh[3] = win_q[1][0];
  assign neigh[4] = win_q[1][2];
  assign neigh[5] = win_q[2][0];
  assign neigh[6] = win_q[2][1];
  assign neigh[7] = win_q[2][2];

  mansm_window_max u_window_max (
    .centre_i (win_q[1][1]),
    .neigh_i  (neigh),
    .mask_i   (s1_ctl_q.mask),
    .slope_o  (slope)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_take) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_take) begin
      out_q.slope         <= slope;
      out_q.last_of_frame <= s1_ctl_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // assertions
  a_frame_rewind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act && frame_end |=> (in_col_q == '0) && (in_row_q == '0))
    else $error("position not rewound after frame end");

  a_window_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_take |-> !in_ready_o)
    else $error("window may shift while its result is pending");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LEN_W'(in_col_q) < LEN_W'(MAX_ROW_LENGTH))
    else $error("column beyond line store depth");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q ##1 out_valid_q |-> $past(s1_valid_q))
    else $error("result without a pending window stage");

endmodule
`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for max_abs_neighbour_slope_map_top. A queue of height
// samples and drain ticks feeds a valid/ready driver. A clocked monitor runs a
// bit-true slope predictor on every accepted transaction and checks each
// result in order. The run covers a directed part, random geometries with
// random stalls on both sides, and a closing frame without stalls.
// ----------------------------------------------------------------------------
module testbench;
  import mansm_pkg::*;

  localparam int unsigned MAX_LEN       = MAX_ROW_LENGTH_DEF;
  localparam logic        CMD_SAMPLE    = ~CMD_DRAIN;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'hA5;
  localparam int unsigned RANDOM_ITEMS  = 900;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned PRINT_MAX     = 40;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  in_item_t  pending[$];
  out_item_t want_slopes[$];
  out_item_t due;

  // predictor state
  sample_t                 upper_line [MAX_LEN];
  sample_t                 lower_line [MAX_LEN];
  sample_t                 win [3][3];
  int unsigned             col_in   = 0;
  int unsigned             row_in   = 0;
  logic [ROW_LENGTH_W-1:0] geo_len  = ROW_LENGTH_RST;
  logic [ROW_COUNT_W-1:0]  geo_rows = ROW_COUNT_RST;

  logic        in_taken = 1'b0;
  int unsigned in_gap   = 0;
  int unsigned out_gap  = 0;
  int unsigned in_odds  = 4;
  int unsigned out_odds = 4;
  sample_t     last_h   = '0;

  int unsigned cycles          = 0;
  int unsigned errors          = 0;
  int unsigned items_taken     = 0;
  int unsigned results_checked = 0;
  int unsigned frames_done     = 0;
  int unsigned geometries      = 0;

  max_abs_neighbour_slope_map_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    if (errors < PRINT_MAX) $display("MISMATCH: %s", msg);
    errors++;
  endtask

  function automatic int unsigned cur_len();
    if (geo_len == 0) return 1;
    if (geo_len > MAX_LEN) return MAX_LEN;
    return geo_len;
  endfunction

  function automatic int unsigned cur_rows();
    return (geo_rows == 0) ? 1 : geo_rows;
  endfunction

  function automatic int unsigned peak_diff(input int cc, input bit lf, input bit rt,
                                            input bit up, input bit dn);
    int unsigned best, mag;
    int rr, cl, dv;
    best = 0;
    for (rr = 0; rr < 3; rr++) begin
      for (cl = cc - 1; cl <= cc + 1; cl++) begin
        if ((rr == 0 && !up) || (rr == 2 && !dn)) continue;
        if (cl < 0 || cl > 2) continue;
        if ((cl < cc && !lf) || (cl > cc && !rt)) continue;
        if (rr == 1 && cl == cc) continue;
        dv = int'(win[1][cc]) - int'(win[rr][cl]);
        mag = (dv < 0) ? -dv : dv;
        if (mag > SLOPE_MAX) mag = SLOPE_MAX;
        if (mag > best) best = mag;
      end
    end
    return best;
  endfunction

  function automatic void advance_map(input in_item_t it);
    int unsigned len, rows, ic, orow, ocol, best;
    bit          drain, emit;
    sample_t     h, up, lo;
    out_item_t   res;
    len   = cur_len();
    rows  = cur_rows();
    drain = (it.cmd == CMD_DRAIN);
    if (row_in < rows && drain) return;  // drain tick inside the frame
    if (row_in >= rows) drain = 1'b1;
    h    = drain ? sample_t'(0) : it.height;
    ic   = (col_in >= MAX_LEN) ? 0 : col_in;
    up   = upper_line[ic];
    lo   = lower_line[ic];
    emit = 1'b0;
    best = 0;
    orow = 0;
    ocol = 0;
    if (ic == 0 && row_in >= 2) begin
      // last column of row_in - 2, from the window before the shift
      orow = row_in - 2;
      ocol = len - 1;
      best = peak_diff(2, len >= 2, 1'b0, orow >= 1, orow + 1 < rows);
      emit = 1'b1;
    end
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = up;
    win[1][2] = lo;
    win[2][2] = h;
    upper_line[ic] = lo;
    lower_line[ic] = h;
    if (ic >= 1 && row_in >= 1) begin
      orow = row_in - 1;
      ocol = ic - 1;
      best = peak_diff(1, ocol >= 1, ocol + 1 < len, orow >= 1, orow + 1 < rows);
      emit = 1'b1;
    end
    if (ic + 1 >= len) begin
      col_in = 0;
      row_in++;
    end else begin
      col_in = ic + 1;
    end
    if (!emit || orow >= rows) return;
    res.slope         = best[SLOPE_W-1:0];
    res.last_of_frame = (orow == rows - 1 && ocol == len - 1);
    if (res.last_of_frame) begin
      col_in = 0;
      row_in = 0;
    end
    want_slopes = {want_slopes, res};
  endfunction

  // driver: input channel
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (in_odds != 0 && $urandom_range(1, in_odds) == 1) begin
        in_valid <= 1'b0;
        in_gap   <= $urandom_range(0, 9);
      end else if (pending.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= pending.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // driver: output backpressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_gap != 0) begin
        out_ready <= 1'b0;
        out_gap   <= out_gap - 1;
      end else if (out_odds != 0 && $urandom_range(1, out_odds) == 1) begin
        out_ready <= 1'b0;
        out_gap   <= $urandom_range(0, 9);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: check results, then predict from the accepted transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (want_slopes.size() == 0) begin
          flag_error($sformatf("unexpected result slope=%0d last=%0b",
                               out_data.slope, out_data.last_of_frame));
        end else begin
          due = want_slopes.pop_front();
          if (out_data.slope !== due.slope)
            flag_error($sformatf("result %0d: slope %0d, expected %0d",
                                 results_checked, out_data.slope, due.slope));
          if (out_data.last_of_frame !== due.last_of_frame)
            flag_error($sformatf("result %0d: last_of_frame %0b, expected %0b",
                                 results_checked, out_data.last_of_frame,
                                 due.last_of_frame));
          if (due.last_of_frame) frames_done++;
        end
        results_checked++;
      end
      if (in_valid && in_ready) begin
        advance_map(in_data);
        items_taken++;
        in_taken <= 1'b1;
      end else begin
        in_taken <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ROW_LENGTH: geo_len = val[ROW_LENGTH_W-1:0];
      CFG_ROW_COUNT:  geo_rows = val[ROW_COUNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] len_word,
                              input logic [CFG_DATA_W-1:0] rows_word);
    write_reg(CFG_ROW_LENGTH, len_word);
    write_reg(CFG_ROW_COUNT, rows_word);
    geometries++;
  endtask

  task automatic settle();
    while (pending.size() != 0 || in_valid || want_slopes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void push_item(input logic c, input sample_t h);
    in_item_t it;
    it.cmd    = c;
    it.height = h;
    pending = {pending, it};
  endfunction

  function automatic sample_t pick_height();
    case ($urandom_range(0, 3))
      0:       last_h = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1:       last_h = last_h + sample_t'($urandom_range(0, 6)) - sample_t'(3);
      default: last_h = sample_t'($urandom);
    endcase
    return last_h;
  endfunction

  function automatic int unsigned pick_odds();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 3;
      default: return 12;
    endcase
  endfunction

  // one frame of the current geometry, with stray drains inside the frame,
  // samples among the drain ticks and stray drains after the frame
  function automatic void queue_frame();
    int unsigned n, k;
    n = cur_len() * cur_rows();
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 24) == 0) push_item(CMD_DRAIN, sample_t'($urandom));
      push_item(CMD_SAMPLE, pick_height());
    end
    for (k = 0; k <= cur_len(); k++) begin
      if ($urandom_range(0, 9) == 0) push_item(CMD_SAMPLE, sample_t'($urandom));
      else push_item(CMD_DRAIN, sample_t'($urandom));
    end
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 3);
      for (k = 0; k < n; k++) push_item(CMD_DRAIN, '0);
    end
  endfunction

  initial begin
    int unsigned random_samples, nframes, len_pick, rows_pick, r, c;
    random_samples = 0;
    for (int k = 0; k < MAX_LEN; k++) begin
      upper_line[k] = '0;
      lower_line[k] = '0;
    end
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) win[k][j] = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: clamped 1x1 frame, stray drain, unmapped register
    write_reg(CFG_UNMAPPED, 16'hFFFF);
    set_geometry(16'h0000, 16'h0000);
    push_item(CMD_DRAIN, 16'sh1234);
    push_item(CMD_SAMPLE, 16'sh7FFF);
    push_item(CMD_DRAIN, '0);
    push_item(CMD_DRAIN, '0);
    settle();

    // directed: single row, saturated difference
    set_geometry(16'd2, 16'd1);
    push_item(CMD_SAMPLE, 16'sh8000);
    push_item(CMD_SAMPLE, 16'sh7FFF);
    repeat (3) push_item(CMD_DRAIN, '0);
    settle();

    // directed: 3x3 of extremes, a sample among the drain ticks
    set_geometry(16'd3, 16'd3);
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 3; c++) begin
        if (r == 1 && c == 1) push_item(CMD_SAMPLE, 16'sh0000);
        else push_item(CMD_SAMPLE, ((r + c) % 2) ? 16'sh7FFF : 16'sh8000);
      end
    end
    push_item(CMD_SAMPLE, -16'sd1);
    repeat (3) push_item(CMD_DRAIN, '0);
    settle();

    // random geometries
    while (random_samples < RANDOM_ITEMS) begin
      in_odds  = pick_odds();
      out_odds = pick_odds();
      case ($urandom_range(0, 7))
        0:       len_pick = 0;
        1:       len_pick = 1;
        2:       len_pick = 2;
        3:       len_pick = 3;
        default: len_pick = $urandom_range(4, 40);
      endcase
      case ($urandom_range(0, 5))
        0:       rows_pick = 0;
        1:       rows_pick = 1;
        2:       rows_pick = 2;
        default: rows_pick = $urandom_range(3, 10);
      endcase
      set_geometry({4'($urandom), 12'(len_pick)}, 16'(rows_pick));
      nframes = $urandom_range(1, 3);
      repeat (nframes) queue_frame();
      random_samples += nframes * cur_len() * cur_rows();
      settle();
    end

    // closing frame, no stalls
    in_odds  = 0;
    out_odds = 0;
    set_geometry(16'd24, 16'd6);
    queue_frame();
    settle();

    $display("Covered %0d frames in %0d geometries: %0d transactions in, %0d results checked.",
             frames_done, geometries, items_taken, results_checked);
    $display("Row lengths ran from 1 to 40 and row counts from 1 to 10, zero settings clamped.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/mansm_pkg.sv
sv/mansm_line_store.sv
sv/mansm_window_max.sv
sv/max_abs_neighbour_slope_map_top.sv
verif/testbench.sv
